/* rtl/core/gete_pkg.sv */
// Shared types, constants and helpers for the Galois element table entry block.
package gete_pkg;

   localparam int ROW_W              = 16;  // row index width
   localparam int COL_W              = 16;  // column index width
   localparam int CFG_W              = 5;   // widest config register
   localparam int CSR_IDX_W          = 2;
   localparam int EXP_W              = 6;   // generator exponent h+1+b, up to 47
   localparam int GEN_PER_STAGE      = 4;   // row bits folded in per generator stage
   localparam int DEF_MAX_LOG_DEGREE = 16;

   localparam logic [CFG_W-1:0] RST_LOG_DEGREE = CFG_W'(12);
   localparam logic [CFG_W-1:0] RST_BASE_LEVEL = CFG_W'(0);
   localparam logic [CFG_W-1:0] RST_TOP_LEVEL  = CFG_W'(0);
   localparam logic             RST_TABLE_KIND = 1'b0;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_LOG_DEGREE = 2'd0,
      REG_BASE_LEVEL = 2'd1,
      REG_TOP_LEVEL  = 2'd2,
      REG_TABLE_KIND = 2'd3
   } csr_reg_type;

   typedef enum logic {
      KIND_PACK   = 1'b0,
      KIND_EXPAND = 1'b1
   } table_kind_type;

   // Effective levels after saturation, shared by all stages.
   typedef struct packed {
      logic [CFG_W-1:0] log_deg;  // L, clamped
      logic [CFG_W-1:0] base;     // h
      logic [CFG_W-1:0] depth;    // u-h, or 0
      logic [CFG_W-1:0] shift;    // L-u
      table_kind_type   kind;
   } lvl_type;

   // Newton steps for an inverse mod 2^w, starting at 3 correct bits.
   function automatic int newton_iters(input int w);
      int n;
      int bits;
      n    = 0;
      bits = 3;
      while (bits < w) begin
         bits = bits * 2;
         n    = n + 1;
      end
      return (n == 0) ? 1 : n;
   endfunction

endpackage

/* rtl/core/gete_gen_stage.sv */
// One generator stage: folds a group of row bits into the running Galois element.
module gete_gen_stage
   import gete_pkg::*;
#(
   parameter int W         = DEF_MAX_LOG_DEGREE + 1,
   parameter int FIRST_BIT = 0
) (
   input  logic             clock,
   input  logic             load,
   input  lvl_type          lvl,
   input  logic [ROW_W-1:0] row_src,
   input  logic [W-1:0]     g_src,
   output logic [ROW_W-1:0] row_ff,
   output logic [W-1:0]     g_ff
);

   logic [W-1:0]     g_in;
   logic [EXP_W-1:0] e;

   // g * (2^e + 1) is a shift and add; exponents past L give a factor of 1.
   always_comb begin
      g_in = g_src;
      e    = '0;
      for (int j = 0; j < GEN_PER_STAGE; j++) begin
         e = EXP_W'(lvl.base) + EXP_W'(FIRST_BIT + j + 1);
         if (row_src[FIRST_BIT + j] && (e <= EXP_W'(lvl.log_deg))) begin
            g_in = g_in + (g_in << e);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         row_ff <= row_src;
         g_ff   <= g_in;
      end
   end

endmodule

/* rtl/core/gete_newton_step.sv */
// One Newton step x <- x*(2 - g*x) mod 2^W, split over two register stages.
module gete_newton_step
   import gete_pkg::*;
#(
   parameter int W = DEF_MAX_LOG_DEGREE + 1
) (
   input  logic         clock,
   input  logic [1:0]   load,
   input  logic [W-1:0] g_src,
   input  logic [W-1:0] x_src,
   output logic [W-1:0] g_ff,
   output logic [W-1:0] x_ff
);

   localparam logic [W-1:0] TWO = W'(2);

   logic [W-1:0]   ga_ff;
   logic [W-1:0]   xa_ff;
   logic [W-1:0]   t_ff;
   logic [2*W-1:0] prod_a;
   logic [2*W-1:0] prod_b;
   logic [W-1:0]   corr;
   logic [W-1:0]   t_in;
   logic [W-1:0]   x_in;

   always_comb begin
      prod_a = {{W{1'b0}}, g_src} * {{W{1'b0}}, x_src};
      t_in   = prod_a[W-1:0];
      corr   = TWO - t_ff;
      prod_b = {{W{1'b0}}, xa_ff} * {{W{1'b0}}, corr};
      x_in   = prod_b[W-1:0];
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         ga_ff <= g_src;
         xa_ff <= x_src;
         t_ff  <= t_in;
      end
      if (load[1]) begin
         g_ff <= ga_ff;
         x_ff <= x_in;
      end
   end

endmodule

/* rtl/core/galois_element_table_entry.sv */
// Top level: pipelined Galois element / inverse / table entry generator.
//
// Usage:
//  - req channel carries a row index and a column index; rsp channel returns the
//    Galois element of the row, its inverse and the table entry, all mod 2N.
//  - A transfer happens on a rising edge with valid high and stall low.
//  - csr_wr_en/csr_index/csr_wdata write log_degree, base_level, top_level and
//    table_kind; write them only while no transfer is in flight.
//  - Depth: GS + 2*NI + 1 register stages, where GS is the number of generator
//    stages (four row bits each) and NI the Newton steps for the inverse. At the
//    default degree limit of 16 that is 11 stages.
//  - Throughput: one transfer per cycle while rsp_stall is low. Each stage has its
//    own valid bit, so bubbles close up while the receiver stalls and new requests
//    keep entering until every stage holds an item.
//  - Reset (synchronous) empties the pipeline and loads the register defaults:
//    log_degree 12, base_level 0, top_level 0, pack table.
module galois_element_table_entry
   import gete_pkg::*;
#(
   parameter int  MAX_LOG_DEGREE = DEF_MAX_LOG_DEGREE,
   localparam int W              = MAX_LOG_DEGREE + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   // config writes
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ROW_W-1:0]     req_row_index,
   input  logic [COL_W-1:0]     req_col_index,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [W-1:0]         rsp_galois_element,
   output logic [W-1:0]         rsp_inverse_element,
   output logic [W-1:0]         rsp_table_entry
);

   localparam int GS = ROW_W / GEN_PER_STAGE;   // generator stages
   localparam int NI = newton_iters(W);        // Newton steps
   localparam int NS = GS + 2 * NI + 1;        // total register stages

   // ---------------------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------------------
   logic [CFG_W-1:0] log_degree_ff;
   logic [CFG_W-1:0] base_level_ff;
   logic [CFG_W-1:0] top_level_ff;
   table_kind_type   table_kind_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         log_degree_ff <= RST_LOG_DEGREE;
         base_level_ff <= RST_BASE_LEVEL;
         top_level_ff  <= RST_TOP_LEVEL;
         table_kind_ff <= table_kind_type'(RST_TABLE_KIND);
      end else if (csr_wr_en) begin
         case (csr_reg_type'(csr_index))
            REG_LOG_DEGREE: log_degree_ff <= csr_wdata;
            REG_BASE_LEVEL: base_level_ff <= csr_wdata;
            REG_TOP_LEVEL:  top_level_ff  <= csr_wdata;
            REG_TABLE_KIND: table_kind_ff <= table_kind_type'(csr_wdata[0]);
            default: ;
         endcase
      end
   end

   // Effective levels. The user keeps config static while items are in flight; the
   // block itself does not enforce this. Stages read these directly, not a copy.
   lvl_type          lvl;
   logic [CFG_W-1:0] u_eff;

   always_comb begin
      lvl.base = base_level_ff;
      lvl.kind = table_kind_ff;
      if (log_degree_ff == '0) begin
         lvl.log_deg = CFG_W'(1);
      end else if (log_degree_ff > CFG_W'(MAX_LOG_DEGREE)) begin
         lvl.log_deg = CFG_W'(MAX_LOG_DEGREE);
      end else begin
         lvl.log_deg = log_degree_ff;
      end
      u_eff     = (top_level_ff > lvl.log_deg) ? lvl.log_deg : top_level_ff;
      lvl.depth = (u_eff > base_level_ff) ? (u_eff - base_level_ff) : '0;
      lvl.shift = lvl.log_deg - u_eff;
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: per-stage valid, ready ripples back from the output
   // ---------------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_src;
   logic [NS-1:0] rdy;
   logic [NS-1:0] ld;

   always_comb begin
      vld_src         = {vld_ff[NS-2:0], req_valid};
      rdy[NS-1]       = !vld_ff[NS-1] || !rsp_stall;
      for (int i = NS - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      ld = rdy & vld_src;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NS; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_src[i];
            end
         end
      end
   end

   assign req_stall = !rdy[0];
   assign rsp_valid = vld_ff[NS-1];

   // ---------------------------------------------------------------------------
   // Input masking and the final multiplier operand
   // ---------------------------------------------------------------------------
   logic [ROW_W-1:0] row_m;
   logic [COL_W-1:0] col_m;
   logic [W-1:0]     col_scaled;
   logic [W-1:0]     op_src;

   always_comb begin
      row_m      = req_row_index & ~({ROW_W{1'b1}} << lvl.depth);
      col_m      = req_col_index & ~({COL_W{1'b1}} << lvl.depth);
      col_scaled = W'(col_m) << lvl.shift;   // k * (N >> u)
      // pack multiplies k*base by the inverse; expand multiplies -k*base by g
      op_src     = (lvl.kind == KIND_EXPAND) ? (W'(0) - col_scaled) : col_scaled;
   end

   // Operand rides along as a delay line up to the last stage.
   logic [W-1:0] op_ff [NS-1];

   always_ff @(posedge clock) begin
      if (ld[0]) begin
         op_ff[0] <= op_src;
      end
      for (int i = 1; i < NS - 1; i++) begin
         if (ld[i]) begin
            op_ff[i] <= op_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Generator stages: product of (2^(h+1+b) + 1) over set row bits
   // ---------------------------------------------------------------------------
   logic [ROW_W-1:0] gen_row [GS];
   logic [W-1:0]     gen_g   [GS];

   for (genvar s = 0; s < GS; s++) begin : g_gen
      logic [ROW_W-1:0] row_s;
      logic [W-1:0]     g_s;
      if (s == 0) begin : g_first
         assign row_s = row_m;
         assign g_s   = W'(1);
      end else begin : g_next
         assign row_s = gen_row[s-1];
         assign g_s   = gen_g[s-1];
      end
      gete_gen_stage #(
         .W         (W),
         .FIRST_BIT (s * GEN_PER_STAGE)
      ) u_gen (
         .clock   (clock),
         .load    (ld[s]),
         .lvl     (lvl),
         .row_src (row_s),
         .g_src   (g_s),
         .row_ff  (gen_row[s]),
         .g_ff    (gen_g[s])
      );
   end

   // ---------------------------------------------------------------------------
   // Inverse by Newton iteration, seeded with g (g*g = 1 mod 8 for odd g)
   // ---------------------------------------------------------------------------
   logic [W-1:0] nt_g [NI];
   logic [W-1:0] nt_x [NI];

   for (genvar n = 0; n < NI; n++) begin : g_newton
      logic [W-1:0] g_n;
      logic [W-1:0] x_n;
      if (n == 0) begin : g_seed
         assign g_n = gen_g[GS-1];
         assign x_n = gen_g[GS-1];
      end else begin : g_chain
         assign g_n = nt_g[n-1];
         assign x_n = nt_x[n-1];
      end
      gete_newton_step #(
         .W (W)
      ) u_newton (
         .clock (clock),
         .load  (ld[GS + 2*n + 1 : GS + 2*n]),
         .g_src (g_n),
         .x_src (x_n),
         .g_ff  (nt_g[n]),
         .x_ff  (nt_x[n])
      );
   end

   // ---------------------------------------------------------------------------
   // Output stage: entry multiply, reduce everything mod 2N
   // ---------------------------------------------------------------------------
   logic [W-1:0]   mod_mask;
   logic [W-1:0]   mul_b;
   logic [2*W-1:0] entry_prod;
   logic [W-1:0]   ge_ff;
   logic [W-1:0]   inv_ff;
   logic [W-1:0]   entry_ff;

   always_comb begin
      mod_mask   = ~({W{1'b1}} << ({1'b0, lvl.log_deg} + 6'd1));
      mul_b      = (lvl.kind == KIND_EXPAND) ? nt_g[NI-1] : nt_x[NI-1];
      entry_prod = {{W{1'b0}}, op_ff[NS-2]} * {{W{1'b0}}, mul_b};
   end

   always_ff @(posedge clock) begin
      if (ld[NS-1]) begin
         ge_ff    <= nt_g[NI-1] & mod_mask;
         inv_ff   <= nt_x[NI-1] & mod_mask;
         entry_ff <= entry_prod[W-1:0] & mod_mask;
      end
   end

   assign rsp_galois_element  = ge_ff;
   assign rsp_inverse_element = inv_ff;
   assign rsp_table_entry     = entry_ff;

endmodule

/* rtl/core/gete_checker.sv */
// Port-level checks for the Galois element table entry block, bound to the top.
module gete_checker
   import gete_pkg::*;
#(
   parameter int  MAX_LOG_DEGREE = DEF_MAX_LOG_DEGREE,
   localparam int W              = MAX_LOG_DEGREE + 1
) (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input logic [W-1:0] rsp_galois_element,
   input logic [W-1:0] rsp_inverse_element,
   input logic [W-1:0] rsp_table_entry
);

   logic [2*W-1:0] gi_prod;

   assign gi_prod = {{W{1'b0}}, rsp_galois_element} * {{W{1'b0}}, rsp_inverse_element};

   // Pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled response holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_galois_element)
         && $stable(rsp_inverse_element) && $stable(rsp_table_entry)))
      else $error("stalled response changed");

   // Element is always odd.
   a_odd_element: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_galois_element[0])
      else $error("even Galois element");

   // Element times inverse is 1 modulo 4 (modulus is at least 4).
   a_inverse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (gi_prod[1:0] == 2'b01))
      else $error("inverse does not match element");

   // Right after reset the pipeline is empty and the request side is not stalled.
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_stall)
      else $error("request stalled with empty pipeline");

endmodule

bind galois_element_table_entry gete_checker #(
   .MAX_LOG_DEGREE (MAX_LOG_DEGREE)
) u_gete_checker (
   .clock               (clock),
   .reset               (reset),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_galois_element  (rsp_galois_element),
   .rsp_inverse_element (rsp_inverse_element),
   .rsp_table_entry     (rsp_table_entry)
);
